// ===== hdl/estp_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// estp_pkg
// Shared types, constants and decode functions for the escape sequence
// token parser.
// ----------------------------------------------------------------------------
package estp_pkg;

  localparam int MAX_HEX_DIGITS = 6;
  localparam int OFFSET_BITS    = 32;
  localparam int LEN_BITS       = $clog2(MAX_HEX_DIGITS + 1);
  localparam int CP_BITS        = 21;
  localparam int BW_BITS        = 3;
  localparam int TOK_BITS       = 24;
  localparam int OUT_OFS_BITS   = 32;

  typedef enum logic [2:0] {
    MODE_IDLE      = 3'd0,
    MODE_ESC       = 3'd1,
    MODE_USEEN     = 3'd2,
    MODE_PAYLOAD   = 3'd3,
    MODE_ERR_BRACE = 3'd4,
    MODE_ERR_LEN   = 3'd5,
    MODE_ERR_HEX   = 3'd6
  } mode_t;

  localparam logic [CP_BITS-1:0] CH_BACKSLASH = 21'h5C;
  localparam logic [CP_BITS-1:0] CH_U         = 21'h75;
  localparam logic [CP_BITS-1:0] CH_LBRACE    = 21'h7B;
  localparam logic [CP_BITS-1:0] CH_RBRACE    = 21'h7D;

  typedef struct packed {
    logic [CP_BITS-1:0] codepoint;
    logic [BW_BITS-1:0] byte_width;
  } item_t;

  typedef struct packed {
    logic [2:0]              status;
    logic                    token_valid;
    logic [TOK_BITS-1:0]     token_codepoint;
    logic                    escaped_literal;
    logic [OUT_OFS_BITS-1:0] token_char_offset;
    logic [OUT_OFS_BITS-1:0] token_byte_offset;
  } result_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } hex_t;

  function automatic hex_t hex_digit(input logic [CP_BITS-1:0] c);
    hex_t h;
    h.ok  = 1'b1;
    h.val = c[3:0];
    if (c >= 21'h30 && c <= 21'h39) begin
      h.val = c[3:0];
    end else if (c >= 21'h41 && c <= 21'h46) begin
      h.val = 4'(c - 21'h41 + 21'd10);
    end else if (c >= 21'h61 && c <= 21'h66) begin
      h.val = 4'(c - 21'h61 + 21'd10);
    end else begin
      h.ok = 1'b0;
    end
    return h;
  endfunction

  // zero means no simple escape
  function automatic logic [TOK_BITS-1:0] simple_escape(input logic [CP_BITS-1:0] c);
    logic [TOK_BITS-1:0] e;
    case (c)
      21'h61:  e = 24'd7;   // a
      21'h62:  e = 24'd8;   // b
      21'h65:  e = 24'd27;  // e
      21'h66:  e = 24'd12;  // f
      21'h6E:  e = 24'd10;  // n
      21'h72:  e = 24'd13;  // r
      21'h74:  e = 24'd9;   // t
      21'h76:  e = 24'd11;  // v
      21'h5C:  e = 24'd92;  // backslash
      default: e = '0;
    endcase
    return e;
  endfunction

endpackage
`default_nettype wire

// ===== hdl/estp_in_stage.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// estp_in_stage
// Input register: holds one accepted beat until the step logic takes it.
// ----------------------------------------------------------------------------
module estp_in_stage (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire estp_pkg::item_t in_item,
  input  wire logic           take,
  output logic                held_valid,
  output estp_pkg::item_t     held_item
);
  import estp_pkg::*;

  assign in_ready = !held_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (in_ready) begin
      held_valid <= in_valid;
    end
    if (in_valid && in_ready) begin
      held_item <= in_item;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/estp_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// estp_core
// Parser state and its combinational step: mode, hex payload, offsets.
// ----------------------------------------------------------------------------
module estp_core (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            step,
  input  wire estp_pkg::item_t item,
  output estp_pkg::result_t    result
);
  import estp_pkg::*;

  mode_t                  mode, mode_next;
  logic [LEN_BITS-1:0]    payload_length, payload_length_next;
  logic [TOK_BITS-1:0]    payload_value, payload_value_next;
  logic [OFFSET_BITS-1:0] char_offset, char_offset_next;
  logic [OFFSET_BITS-1:0] byte_count, byte_count_next;
  logic [OFFSET_BITS-1:0] start_char_offset, start_char_offset_next;
  logic [OFFSET_BITS-1:0] start_byte_offset, start_byte_offset_next;

  logic                tok_valid;
  logic [TOK_BITS-1:0] tok;
  logic                lit;
  logic                active;
  logic [TOK_BITS-1:0] esc;
  hex_t                hx;

  always_comb begin
    mode_next              = mode;
    payload_length_next    = payload_length;
    payload_value_next     = payload_value;
    start_char_offset_next = start_char_offset;
    start_byte_offset_next = start_byte_offset;
    tok_valid              = 1'b0;
    tok                    = '0;
    lit                    = 1'b0;
    active                 = 1'b1;
    esc                    = simple_escape(item.codepoint);
    hx                     = hex_digit(item.codepoint);

    case (mode)
      MODE_IDLE: begin
        start_char_offset_next = char_offset;
        start_byte_offset_next = byte_count;
        if (item.codepoint == CH_BACKSLASH) begin
          mode_next = MODE_ESC;
        end else begin
          tok_valid = 1'b1;
          tok       = TOK_BITS'(item.codepoint);
        end
      end
      MODE_ESC: begin
        if (esc != '0) begin
          tok_valid = 1'b1;
          tok       = esc;
          mode_next = MODE_IDLE;
        end else if (item.codepoint == CH_U) begin
          mode_next = MODE_USEEN;
        end else begin
          tok_valid = 1'b1;
          tok       = TOK_BITS'(item.codepoint);
          lit       = 1'b1;
          mode_next = MODE_IDLE;
        end
      end
      MODE_USEEN: begin
        if (item.codepoint == CH_LBRACE) begin
          mode_next           = MODE_PAYLOAD;
          payload_length_next = '0;
          payload_value_next  = '0;
        end else begin
          mode_next = MODE_ERR_BRACE;
        end
      end
      MODE_PAYLOAD: begin
        if (item.codepoint == CH_RBRACE) begin
          tok_valid = 1'b1;
          tok       = payload_value;
          mode_next = MODE_IDLE;
        end else if (payload_length >= LEN_BITS'(MAX_HEX_DIGITS)) begin
          mode_next = MODE_ERR_LEN;
        end else begin
          payload_length_next = payload_length + LEN_BITS'(1);
          if (!hx.ok) begin
            mode_next = MODE_ERR_HEX;
          end else begin
            payload_value_next = {payload_value[TOK_BITS-5:0], hx.val};
          end
        end
      end
      // error modes are sticky and freeze the offsets
      default: begin
        active = 1'b0;
      end
    endcase

    char_offset_next = active ? char_offset + OFFSET_BITS'(1) : char_offset;
    byte_count_next  = active ? byte_count + OFFSET_BITS'(item.byte_width) : byte_count;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode              <= MODE_IDLE;
      payload_length    <= '0;
      payload_value     <= '0;
      char_offset       <= '0;
      byte_count        <= '0;
      start_char_offset <= '0;
      start_byte_offset <= '0;
    end else if (step) begin
      mode              <= mode_next;
      payload_length    <= payload_length_next;
      payload_value     <= payload_value_next;
      char_offset       <= char_offset_next;
      byte_count        <= byte_count_next;
      start_char_offset <= start_char_offset_next;
      start_byte_offset <= start_byte_offset_next;
    end
  end

  always_comb begin
    result.status            = mode_next;
    result.token_valid       = tok_valid;
    result.token_codepoint   = tok;
    result.escaped_literal   = lit;
    result.token_char_offset = OUT_OFS_BITS'(start_char_offset_next);
    result.token_byte_offset = OUT_OFS_BITS'(start_byte_offset_next);
  end

endmodule
`default_nettype wire

// ===== hdl/estp_out_stage.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// estp_out_stage
// Result register: loads a result whenever the slot is free or being drained.
// ----------------------------------------------------------------------------
module estp_out_stage (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              src_valid,
  output logic                   take,
  input  wire estp_pkg::result_t src_result,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output estp_pkg::result_t      out_result
);
  import estp_pkg::*;

  assign take = src_valid && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      out_valid <= src_valid;
    end
    if (take) begin
      out_result <= src_result;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/escape_sequence_token_parser.sv =====
// Path: an accepted beat waits in the input register; its result is loaded into
// the result register once that slot is free. Throughput: one beat per cycle
// while out_ready is high; the combinational state step lies between the two.
// Reset: synchronous rst returns the parser to idle with all offsets at zero
// and empties both registers.
`default_nettype none
// ----------------------------------------------------------------------------
// escape_sequence_token_parser
// Backslash and \u{hex} escape decoder producing one result beat per character.
// ----------------------------------------------------------------------------
module escape_sequence_token_parser (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               in_valid,
  output logic                                    in_ready,
  input  wire logic [estp_pkg::CP_BITS-1:0]       codepoint,
  input  wire logic [estp_pkg::BW_BITS-1:0]       byte_width,
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output logic [2:0]                              status,
  output logic                                    token_valid,
  output logic [estp_pkg::TOK_BITS-1:0]           token_codepoint,
  output logic                                    escaped_literal,
  output logic [estp_pkg::OUT_OFS_BITS-1:0]       token_char_offset,
  output logic [estp_pkg::OUT_OFS_BITS-1:0]       token_byte_offset
);
  import estp_pkg::*;

  item_t   in_item;
  item_t   held_item;
  logic    held_valid;
  logic    take;
  result_t step_result;
  result_t out_result;

  assign in_item.codepoint  = codepoint;
  assign in_item.byte_width = byte_width;

  estp_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_item    (in_item),
    .take       (take),
    .held_valid (held_valid),
    .held_item  (held_item)
  );

  estp_core u_core (
    .clk    (clk),
    .rst    (rst),
    .step   (take),
    .item   (held_item),
    .result (step_result)
  );

  estp_out_stage u_out (
    .clk        (clk),
    .rst        (rst),
    .src_valid  (held_valid),
    .take       (take),
    .src_result (step_result),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_result (out_result)
  );

  assign status            = out_result.status;
  assign token_valid       = out_result.token_valid;
  assign token_codepoint   = out_result.token_codepoint;
  assign escaped_literal   = out_result.escaped_literal;
  assign token_char_offset = out_result.token_char_offset;
  assign token_byte_offset = out_result.token_byte_offset;

endmodule
`default_nettype wire
